// File: src/gesr_pkg.sv
// Package for the gated edge sampler and rpm meter.
// Holds field widths, register defaults, codes and the controller state type.
// No dependencies.
package gesr_pkg;

    localparam int unsigned RING_DEPTH_DEF = 1024;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned SLOT_OUT_W = 10;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned RPM_W      = 16;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned CFG8_W     = 8;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    // rpm = floor(6000000 * edges / (pulses_per_rev * window * 270))
    localparam int unsigned NUM_W = 39;
    localparam int unsigned DEN_W = 33;
    localparam int unsigned REM_W = 33;
    localparam logic [NUM_W-1:0] RPM_NUM_K = NUM_W'(6000000);
    localparam logic [DEN_W-1:0] RPM_DEN_K = DEN_W'(270);

    localparam int unsigned STEP_W    = 6;
    localparam int unsigned MUL_STEPS = CNT_W;
    localparam int unsigned DIV_STEPS = NUM_W;

    localparam logic [CFG8_W-1:0] HOLD_COUNT_RST     = 8'd5;
    localparam logic [CFG8_W-1:0] SKIP_COUNT_RST     = 8'd3;
    localparam logic [CFG_W-1:0]  WINDOW_TICKS_RST   = 16'd15000;
    localparam logic [CFG8_W-1:0] PULSES_PER_REV_RST = 8'd68;
    localparam logic [CFG8_W-1:0] TICK_PERIOD_US_RST = 8'd10;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_COUNT     = 3'd0,
        REG_SKIP_COUNT     = 3'd1,
        REG_WINDOW_TICKS   = 3'd2,
        REG_PULSES_PER_REV = 3'd3,
        REG_TICK_PERIOD_US = 3'd4
    } gesr_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_STAMP,
        ST_DIV,
        ST_DONE
    } gesr_state_t;

    function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// File: src/gated_edge_sampler_rpm_meter_unit.sv
// Gated edge sampler with M-method rpm meter, top level.
// Depends on gesr_pkg.
//
// Ticks and edges arrive on one valid/ready input channel. A tick, or an edge
// that neither samples nor closes the window, is absorbed without leaving idle.
// An edge that samples runs bit-serial multipliers (timestamp, divisor and
// dividend are formed one bit a cycle), then passes the stamp and done states.
// An edge that closes the measurement window also runs a restoring divider,
// one quotient bit a cycle over the 39-bit dividend, between stamp and done.
// The result word sits in an output register, so the next item is taken while
// it waits. Configuration writes take effect at once and belong in idle time.
module gated_edge_sampler_rpm_meter_unit
    import gesr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [SAMPLE_W-1:0]   adc_sample,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  sample_valid,
    output logic [SAMPLE_W-1:0]   sample_value,
    output logic [SLOT_OUT_W-1:0] sample_slot,
    output logic                  interval_valid,
    output logic [INTERVAL_W-1:0] interval_us,
    output logic                  rpm_valid,
    output logic [RPM_W-1:0]      rpm
);

    localparam int unsigned SLOT_W = $clog2(RING_DEPTH);

    // configuration
    logic [CFG8_W-1:0] hold_count_reg;
    logic [CFG8_W-1:0] skip_count_reg;
    logic [CFG_W-1:0]  window_ticks_reg;
    logic [CFG8_W-1:0] pulses_per_rev_reg;
    logic [CFG8_W-1:0] tick_period_us_reg;

    // architectural state
    logic [TICK_W-1:0] tick_total_reg;
    logic [CNT_W-1:0]  window_count_reg;
    logic [CNT_W-1:0]  edge_count_reg;
    logic [CFG8_W-1:0] taken_reg;
    logic [CFG8_W-1:0] skips_left_reg;
    logic [TICK_W-1:0] last_stamp_reg;
    logic              have_prev_reg;
    logic [SLOT_W-1:0] slot_ptr_reg;

    // controller
    gesr_state_t       state_reg;
    gesr_state_t       state_next;
    logic [STEP_W-1:0] step_reg;
    logic              in_acc;
    logic              load_out;

    // per-edge work registers
    logic                  take_reg;
    logic                  close_reg;
    logic                  int_valid_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [TICK_W-1:0]     tt_sh_reg;
    logic [CFG8_W-1:0]     tp_sh_reg;
    logic [TICK_W-1:0]     stamp_reg;
    logic [CFG8_W-1:0]     pp_sh_reg;
    logic [DEN_W-1:0]      wk_sh_reg;
    logic [DEN_W-1:0]      d_acc_reg;
    logic [CNT_W-1:0]      e_sh_reg;
    logic [NUM_W-1:0]      c_sh_reg;
    logic [NUM_W-1:0]      n_acc_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [RPM_W-1:0]      quo_reg;
    logic                  ovf_reg;

    // output word
    logic                  out_valid_reg;
    logic                  sample_valid_reg;
    logic [SAMPLE_W-1:0]   sample_value_reg;
    logic [SLOT_OUT_W-1:0] sample_slot_reg;
    logic                  interval_valid_reg;
    logic [INTERVAL_W-1:0] interval_us_reg;
    logic                  rpm_valid_reg;
    logic [RPM_W-1:0]      rpm_reg;

    logic              take_now;
    logic              close_now;
    logic [CNT_W-1:0]  edge_inc;
    logic [SLOT_W-1:0] slot_ptr_next;
    logic [REM_W:0]    div_trial;
    logic [REM_W:0]    div_diff;
    logic              div_ge;

    assign take_now  = taken_reg < hold_count_reg;
    assign close_now = window_count_reg >= window_ticks_reg;
    assign edge_inc  = sat_inc16(edge_count_reg);
    assign slot_ptr_next = (slot_ptr_reg == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                     : slot_ptr_reg + 1'b1;

    assign div_trial = {rem_reg, n_acc_reg[NUM_W-1]};
    assign div_diff  = div_trial - {1'b0, d_acc_reg};
    assign div_ge    = div_trial >= {1'b0, d_acc_reg};

    assign in_acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
                step_reg <= '0;
            else if (state_reg == ST_MUL || state_reg == ST_DIV)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && opcode == OP_EDGE && (take_now || close_now))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                    state_next = ST_STAMP;
            end
            ST_STAMP:
            begin
                state_next = close_reg ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration and gating/counting state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg     <= HOLD_COUNT_RST;
            skip_count_reg     <= SKIP_COUNT_RST;
            window_ticks_reg   <= WINDOW_TICKS_RST;
            pulses_per_rev_reg <= PULSES_PER_REV_RST;
            tick_period_us_reg <= TICK_PERIOD_US_RST;
            tick_total_reg     <= '0;
            window_count_reg   <= '0;
            edge_count_reg     <= '0;
            taken_reg          <= '0;
            skips_left_reg     <= SKIP_COUNT_RST;
            last_stamp_reg     <= '0;
            have_prev_reg      <= 1'b0;
            slot_ptr_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOLD_COUNT:     hold_count_reg     <= cfg_wdata[CFG8_W-1:0];
                    REG_SKIP_COUNT:     skip_count_reg     <= cfg_wdata[CFG8_W-1:0];
                    REG_WINDOW_TICKS:   window_ticks_reg   <= cfg_wdata;
                    REG_PULSES_PER_REV: pulses_per_rev_reg <= cfg_wdata[CFG8_W-1:0];
                    REG_TICK_PERIOD_US: tick_period_us_reg <= cfg_wdata[CFG8_W-1:0];
                    default:            ;
                endcase
            end

            if (in_acc)
            begin
                if (opcode == OP_TICK)
                begin
                    tick_total_reg   <= tick_total_reg + 1'b1;
                    window_count_reg <= sat_inc16(window_count_reg);
                end
                else
                begin
                    if (take_now)
                    begin
                        taken_reg     <= taken_reg + 1'b1;
                        slot_ptr_reg  <= slot_ptr_next;
                        have_prev_reg <= 1'b1;
                    end
                    else if (skips_left_reg == '0)
                    begin
                        // restart edge
                        taken_reg      <= '0;
                        skips_left_reg <= skip_count_reg;
                    end
                    else
                    begin
                        skips_left_reg <= skips_left_reg - 1'b1;
                    end

                    if (close_now)
                    begin
                        edge_count_reg   <= '0;
                        window_count_reg <= '0;
                    end
                    else
                    begin
                        edge_count_reg <= edge_inc;
                    end
                end
            end

            if (state_reg == ST_STAMP && take_reg)
                last_stamp_reg <= stamp_reg;
        end
    end

    // serial datapath: shift-add multipliers, then restoring divider
    always_ff @(posedge clk)
    begin
        if (in_acc && opcode == OP_EDGE)
        begin
            take_reg      <= take_now;
            close_reg     <= close_now;
            int_valid_reg <= have_prev_reg;
            sample_reg    <= adc_sample;
            slot_reg      <= slot_ptr_reg;
            tt_sh_reg     <= tick_total_reg;
            tp_sh_reg     <= tick_period_us_reg;
            stamp_reg     <= '0;
            pp_sh_reg     <= pulses_per_rev_reg;
            wk_sh_reg     <= DEN_W'(window_count_reg) * RPM_DEN_K;
            d_acc_reg     <= '0;
            e_sh_reg      <= edge_inc;
            c_sh_reg      <= RPM_NUM_K;
            n_acc_reg     <= '0;
        end

        case (state_reg)
            ST_MUL:
            begin
                if (tp_sh_reg[0])
                    stamp_reg <= stamp_reg + tt_sh_reg;
                tt_sh_reg <= tt_sh_reg << 1;
                tp_sh_reg <= tp_sh_reg >> 1;
                if (pp_sh_reg[0])
                    d_acc_reg <= d_acc_reg + wk_sh_reg;
                wk_sh_reg <= wk_sh_reg << 1;
                pp_sh_reg <= pp_sh_reg >> 1;
                if (e_sh_reg[0])
                    n_acc_reg <= n_acc_reg + c_sh_reg;
                c_sh_reg <= c_sh_reg << 1;
                e_sh_reg <= e_sh_reg >> 1;
                rem_reg  <= '0;
                quo_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
            ST_STAMP:
            begin
                interval_reg <= INTERVAL_W'(stamp_reg - last_stamp_reg);
            end
            ST_DIV:
            begin
                rem_reg   <= div_ge ? div_diff[REM_W-1:0] : div_trial[REM_W-1:0];
                n_acc_reg <= n_acc_reg << 1;
                quo_reg   <= {quo_reg[RPM_W-2:0], div_ge};
                // any quotient bit above the 16-bit range saturates the result
                ovf_reg   <= ovf_reg | quo_reg[RPM_W-1];
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            sample_valid_reg   <= take_reg;
            sample_value_reg   <= take_reg ? sample_reg : '0;
            sample_slot_reg    <= take_reg ? SLOT_OUT_W'(slot_reg) : '0;
            interval_valid_reg <= take_reg && int_valid_reg;
            interval_us_reg    <= (take_reg && int_valid_reg) ? interval_reg : '0;
            rpm_valid_reg      <= close_reg;
            rpm_reg            <= !close_reg ? '0 : (ovf_reg ? {RPM_W{1'b1}} : quo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign sample_valid   = sample_valid_reg;
    assign sample_value   = sample_value_reg;
    assign sample_slot    = sample_slot_reg;
    assign interval_valid = interval_valid_reg;
    assign interval_us    = interval_us_reg;
    assign rpm_valid      = rpm_valid_reg;
    assign rpm            = rpm_reg;

endmodule

// File: src/gesr_checker.sv
// Port-level checks for the gated edge sampler and rpm meter, with its bind.
// Depends on gesr_pkg and gated_edge_sampler_rpm_meter_unit.
module gesr_checker
    import gesr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  sample_valid,
    input logic [SAMPLE_W-1:0]   sample_value,
    input logic [SLOT_OUT_W-1:0] sample_slot,
    input logic                  interval_valid,
    input logic [INTERVAL_W-1:0] interval_us,
    input logic                  rpm_valid,
    input logic [RPM_W-1:0]      rpm
);

    // a word always carries a sample or an rpm value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_valid || rpm_valid))
        else $error("empty result word");

    // an interval only comes with a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && interval_valid) |-> sample_valid)
        else $error("interval without sample");

    // fields of absent parts read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((sample_valid || (sample_value == '0 && sample_slot == '0))
                       && (interval_valid || interval_us == '0)
                       && (rpm_valid || rpm == '0)))
        else $error("stale field in result word");

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_value)
                                       && $stable(sample_slot) && $stable(rpm)
                                       && $stable(interval_us)))
        else $error("result word changed while stalled");

endmodule

bind gated_edge_sampler_rpm_meter_unit gesr_checker u_gesr_checker (.*);
